// ----- rtl/chdg_pkg.sv -----
// Shared constants and the arctangent table for the compass heading CORDIC core.
package chdg_pkg;

  // Pipeline depth: one micro-rotation per register stage (12..24)
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned TABLE_LEN     = 24;

  // Vector components: 16-bit sample, 16 fraction bits, room for sign, negation and gain
  localparam int unsigned XW = 36;
  // Angle accumulator: degrees with 16 fraction bits, covers (-100, 280) degrees
  localparam int unsigned ZW = 26;
  localparam int unsigned HW = 9;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360 * 65536);

  // Headings handed out directly for the exact cases
  localparam logic [HW-1:0] HDG_0   = HW'(0);
  localparam logic [HW-1:0] HDG_45  = HW'(45);
  localparam logic [HW-1:0] HDG_90  = HW'(90);
  localparam logic [HW-1:0] HDG_135 = HW'(135);
  localparam logic [HW-1:0] HDG_180 = HW'(180);
  localparam logic [HW-1:0] HDG_225 = HW'(225);
  localparam logic [HW-1:0] HDG_270 = HW'(270);
  localparam logic [HW-1:0] HDG_315 = HW'(315);

  // atan(2^-i) in degrees, scaled by 65536, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

endpackage

// ----- rtl/compass_heading_atan2_core.sv -----
// Top level: pipelined CORDIC vectoring core that turns a magnetometer (x, y) word into a heading.
//
// Usage
//   Input channel: drive mag_x_i / mag_y_i (signed 16 bit) and raise start_i. A word
//   is taken at every rising edge where start_i is high and busy_o is low. busy_o
//   is held low: the core takes a new word in every cycle.
//   Result channel: heading_deg_o (0..359, whole degrees, fraction dropped) is shown
//   for exactly one cycle with done_o high. The receiver cannot hold results off and
//   the core never needs it to: words leave in the order they came in.
// Pipeline
//   One entry stage (half-plane fold and exact-case detection), CORDIC_STAGES
//   micro-rotation stages, one wrap/output stage, each registered. One word per
//   cycle sustained, since busy_o is never raised; each micro-rotation stage
//   holds one 36-bit add/sub pair for x and y.
// Reset
//   rst_ni (async, active low) clears every valid bit; data registers are not reset.
//   No state is kept between words.
module compass_heading_atan2_core
  import chdg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [15:0]   mag_x_i,
  input  logic signed [15:0]   mag_y_i,
  output logic                 done_o,
  output logic [HW-1:0]        heading_deg_o
);

  localparam int unsigned NS = CORDIC_STAGES;

  logic accept;

  // Entry stage signals
  logic signed [16:0]   ax, ay;
  logic                 sp_d;
  logic [HW-1:0]        spv_d;
  logic signed [XW-1:0] x_ext, y_ext;

  // Per-stage pipeline registers, index 0 is the entry stage
  logic                 v_q   [NS+1];
  logic                 sp_q  [NS+1];
  logic [HW-1:0]        spv_q [NS+1];
  logic signed [XW-1:0] x_q   [NS+1];
  logic signed [XW-1:0] y_q   [NS+1];
  logic signed [ZW-1:0] z_q   [NS+1];
  logic signed [XW-1:0] x_d   [NS+1];
  logic signed [XW-1:0] y_d   [NS+1];
  logic signed [ZW-1:0] z_d   [NS+1];

  // Output stage
  logic signed [ZW-1:0] z_wrap;
  logic [HW-1:0]        heading_d, heading_q;
  logic                 done_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------------
  // Entry stage: exact cases and fold of the left half plane
  // ---------------------------------------------------------------------------
  always_comb begin
    ax = mag_x_i[15] ? -17'(mag_x_i) : 17'(mag_x_i);
    ay = mag_y_i[15] ? -17'(mag_y_i) : 17'(mag_y_i);

    sp_d  = 1'b1;
    spv_d = HDG_0;
    if (mag_x_i == 16'sd0 && mag_y_i == 16'sd0) begin
      spv_d = HDG_0;
    end else if (mag_y_i == 16'sd0) begin
      spv_d = mag_x_i[15] ? HDG_180 : HDG_0;
    end else if (mag_x_i == 16'sd0) begin
      spv_d = mag_y_i[15] ? HDG_270 : HDG_90;
    end else if (ax == ay) begin
      if (!mag_x_i[15]) begin
        spv_d = mag_y_i[15] ? HDG_315 : HDG_45;
      end else begin
        spv_d = mag_y_i[15] ? HDG_225 : HDG_135;
      end
    end else begin
      sp_d = 1'b0;
    end

    // sample scaled by 2^16
    x_ext = {{(XW-32){mag_x_i[15]}}, mag_x_i, 16'h0000};
    y_ext = {{(XW-32){mag_y_i[15]}}, mag_y_i, 16'h0000};
    if (mag_x_i[15]) begin
      x_d[0] = -x_ext;
      y_d[0] = -y_ext;
      z_d[0] = HALF_TURN;
    end else begin
      x_d[0] = x_ext;
      y_d[0] = y_ext;
      z_d[0] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q[0]  <= sp_d;
    spv_q[0] <= spv_d;
    x_q[0]   <= x_d[0];
    y_q[0]   <= y_d[0];
    z_q[0]   <= z_d[0];
  end

  // ---------------------------------------------------------------------------
  // Micro-rotation stages: stage k rotates by atan(2^-k) toward y = 0
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NS; k++) begin : g_rot
    always_comb begin
      if (!y_q[k][XW-1]) begin
        x_d[k+1] = x_q[k] + (y_q[k] >>> k);
        y_d[k+1] = y_q[k] - (x_q[k] >>> k);
        z_d[k+1] = z_q[k] + ATAN_DEG_Q16[k];
      end else begin
        x_d[k+1] = x_q[k] - (y_q[k] >>> k);
        y_d[k+1] = y_q[k] + (x_q[k] >>> k);
        z_d[k+1] = z_q[k] - ATAN_DEG_Q16[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sp_q[k+1]  <= sp_q[k];
      spv_q[k+1] <= spv_q[k];
      x_q[k+1]   <= x_d[k+1];
      y_q[k+1]   <= y_d[k+1];
      z_q[k+1]   <= z_d[k+1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: wrap negative angles into [0, 360) and drop the fraction
  // ---------------------------------------------------------------------------
  always_comb begin
    z_wrap = z_q[NS][ZW-1] ? (z_q[NS] + FULL_TURN) : z_q[NS];
    heading_d = sp_q[NS] ? spv_q[NS] : z_wrap[16 +: HW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= heading_d;
  end

  assign done_o        = done_q;
  assign heading_deg_o = heading_q;

endmodule
